@@ rtl/bbr_pkg.sv @@
// bbr_pkg: codes, field types and the per-block classification struct
// for the block bitmap reconciler. No dependencies.
package bbr_pkg;

  typedef logic [1:0]  state_t;
  typedef logic [3:0]  mark_t;
  typedef logic [1:0]  fix_t;
  typedef logic [1:0]  action_t;
  typedef logic [4:0]  cnt_mask_t;
  typedef logic [31:0] count_t;
  typedef logic [63:0] blkno_t;
  typedef logic [2:0]  cfg_idx_t;

  // allocation states
  localparam state_t ST_FREE      = 2'd0;
  localparam state_t ST_USED      = 2'd1;
  localparam state_t ST_FREE_META = 2'd2;
  localparam state_t ST_USED_META = 2'd3;

  // checker marks
  localparam mark_t MARK_FREE      = 4'd0;
  localparam mark_t MARK_USED      = 4'd1;
  localparam mark_t MARK_FREE_META = 4'd2;
  localparam mark_t MARK_BAD_META  = 4'd3;
  localparam mark_t MARK_INODE_LO  = 4'd4;
  localparam mark_t MARK_INODE_HI  = 4'd10;
  localparam mark_t MARK_INDIR     = 4'd11;
  localparam mark_t MARK_XATTR     = 4'd15;

  // fix kinds
  localparam fix_t FIX_NONE    = 2'd0;
  localparam fix_t FIX_AUTO    = 2'd1;
  localparam fix_t FIX_RO      = 2'd2;
  localparam fix_t FIX_CONFIRM = 2'd3;

  // header actions
  localparam action_t HA_NONE    = 2'd0;
  localparam action_t HA_CONVERT = 2'd1;
  localparam action_t HA_FULL    = 2'd2;

  // count mismatch mask bits
  localparam cnt_mask_t MASK_FREE       = 5'd1;
  localparam cnt_mask_t MASK_USED_INODE = 5'd2;
  localparam cnt_mask_t MASK_FREE_INODE = 5'd4;
  localparam cnt_mask_t MASK_USED_META  = 5'd8;
  localparam cnt_mask_t MASK_FREE_META  = 5'd16;
  localparam cnt_mask_t CONVERT_ONLY_BITS = MASK_FREE | MASK_FREE_META;

  // configuration register indexes
  localparam cfg_idx_t CFG_FIRST_DATA_BLOCK = 3'd0;
  localparam cfg_idx_t CFG_HDR_FREE         = 3'd1;
  localparam cfg_idx_t CFG_HDR_USED_INODE   = 3'd2;
  localparam cfg_idx_t CFG_HDR_FREE_INODE   = 3'd3;
  localparam cfg_idx_t CFG_HDR_USED_META    = 3'd4;
  localparam cfg_idx_t CFG_HDR_FREE_META    = 3'd5;
  localparam cfg_idx_t CFG_READ_ONLY        = 3'd6;

  localparam count_t CNT_MAX = 32'hFFFF_FFFF;

  // which counter a block bumps
  typedef enum logic [2:0] {
    CNT_NONE,
    CNT_FREE,
    CNT_INODE,
    CNT_META,
    CNT_FREE_META
  } cnt_kind_t;

  typedef struct packed {
    state_t    expected;
    logic      mismatch;
    fix_t      fix;
    cnt_kind_t kind;
  } cls_t;

endpackage

@@ rtl/bbr_if.sv @@
// bbr_in_if / bbr_out_if: valid-ready channels of the block bitmap reconciler.
// Depends on bbr_pkg.
interface bbr_in_if;
  import bbr_pkg::*;
  logic   valid;
  logic   ready;
  state_t disk_state;
  mark_t  block_mark;
  logic   last_block;

  modport source (output valid, disk_state, block_mark, last_block, input ready);
  modport sink   (input valid, disk_state, block_mark, last_block, output ready);
endinterface

interface bbr_out_if;
  import bbr_pkg::*;
  logic      valid;
  logic      ready;
  blkno_t    block_number;
  logic      mismatch;
  state_t    expected_state;
  fix_t      fix_kind;
  logic      summary_valid;
  cnt_mask_t count_mismatch_mask;
  action_t   header_action;
  count_t    free_total;
  count_t    used_inode_total;
  count_t    used_meta_total;
  count_t    free_meta_total;

  modport source (output valid, block_number, mismatch, expected_state, fix_kind,
                  summary_valid, count_mismatch_mask, header_action, free_total,
                  used_inode_total, used_meta_total, free_meta_total,
                  input ready);
  modport sink   (input valid, block_number, mismatch, expected_state, fix_kind,
                  summary_valid, count_mismatch_mask, header_action, free_total,
                  used_inode_total, used_meta_total, free_meta_total,
                  output ready);
  modport mon    (input valid, ready, block_number, mismatch, expected_state,
                  fix_kind, summary_valid, count_mismatch_mask, header_action,
                  free_total, used_inode_total, used_meta_total, free_meta_total);
endinterface

@@ rtl/bbr_classify.sv @@
// bbr_classify: maps a block mark to its expected state and counter, and
// grades the on-disk state against it. Depends on bbr_pkg.
module bbr_classify (
  input  bbr_pkg::state_t disk_state,
  input  bbr_pkg::mark_t  block_mark,
  input  logic            read_only,
  output bbr_pkg::cls_t   cls
);
  import bbr_pkg::*;

  state_t    expected;
  cnt_kind_t kind;
  logic      mism;

  always_comb begin
    unique case (block_mark) inside
      MARK_FREE, MARK_BAD_META: begin
        expected = ST_FREE;
        kind     = CNT_FREE;
      end
      MARK_FREE_META: begin
        expected = ST_FREE_META;
        kind     = CNT_FREE_META;
      end
      MARK_USED: begin
        expected = ST_USED;
        kind     = CNT_NONE;
      end
      [MARK_INODE_LO:MARK_INODE_HI]: begin
        expected = ST_USED_META;
        kind     = CNT_INODE;
      end
      [MARK_INDIR:MARK_XATTR]: begin
        expected = ST_USED_META;
        kind     = CNT_META;
      end
      default: begin
        expected = ST_USED_META;
        kind     = CNT_META;
      end
    endcase
  end

  assign mism = (disk_state != expected);

  always_comb begin
    cls.expected = expected;
    cls.mismatch = mism;
    cls.kind     = kind;
    if (!mism) begin
      cls.fix = FIX_NONE;
    end else if (disk_state == ST_FREE_META && expected == ST_FREE) begin
      cls.fix = read_only ? FIX_RO : FIX_AUTO;
    end else begin
      cls.fix = FIX_CONFIRM;
    end
  end

endmodule

@@ rtl/block_bitmap_reconciler_unit.sv @@
// Block bitmap reconciler, top level: input register, classification, group
// counters and result register. Depends on bbr_pkg, bbr_if and bbr_classify.
// An accepted item is held in the input register, then in the result register.
// Throughput: one item per cycle; the input register and the result register
//   advance together whenever the result register is empty or being taken.
// Reset (rst_n, synchronous, low): empties both registers, clears counters,
//   block offset and all configuration registers. No clearing pass.
module block_bitmap_reconciler_unit (
  input  logic                clk,
  input  logic                rst_n,
  bbr_in_if.sink              in_ch,
  bbr_out_if.source           out_ch,
  input  logic                cfg_we,
  input  bbr_pkg::cfg_idx_t   cfg_index,
  input  logic [63:0]         cfg_wdata
);
  import bbr_pkg::*;

  // ---------------------------------------------------------------- config
  blkno_t first_data_block_r;
  count_t hdr_free_r, hdr_used_inode_r, hdr_free_inode_r;
  count_t hdr_used_meta_r, hdr_free_meta_r;
  logic   read_only_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_data_block_r <= '0;
      hdr_free_r         <= '0;
      hdr_used_inode_r   <= '0;
      hdr_free_inode_r   <= '0;
      hdr_used_meta_r    <= '0;
      hdr_free_meta_r    <= '0;
      read_only_r        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_DATA_BLOCK: first_data_block_r <= cfg_wdata;
        CFG_HDR_FREE:         hdr_free_r         <= cfg_wdata[31:0];
        CFG_HDR_USED_INODE:   hdr_used_inode_r   <= cfg_wdata[31:0];
        CFG_HDR_FREE_INODE:   hdr_free_inode_r   <= cfg_wdata[31:0];
        CFG_HDR_USED_META:    hdr_used_meta_r    <= cfg_wdata[31:0];
        CFG_HDR_FREE_META:    hdr_free_meta_r    <= cfg_wdata[31:0];
        CFG_READ_ONLY:        read_only_r        <= cfg_wdata[0];
        default: ; // unmapped index: dropped
      endcase
    end
  end

  // ------------------------------------------------------ handshake control
  logic s1_valid_r, out_valid_r;
  logic adv;   // result register may load this cycle

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || adv;

  // ---------------------------------------------------------- input stage
  state_t s1_disk_r;
  mark_t  s1_mark_r;
  logic   s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_disk_r <= in_ch.disk_state;
      s1_mark_r <= in_ch.block_mark;
      s1_last_r <= in_ch.last_block;
    end
  end

  // ------------------------------------------------------- classification
  cls_t cls;

  bbr_classify u_cls (
    .disk_state (s1_disk_r),
    .block_mark (s1_mark_r),
    .read_only  (read_only_r),
    .cls        (cls)
  );

  // ---------------------------------------------------------- group counts
  // Counts include the current block; each saturates at all ones.
  count_t offset_r, free_cnt_r, inode_cnt_r, meta_cnt_r, fmeta_cnt_r;
  count_t free_cnt_nxt, inode_cnt_nxt, meta_cnt_nxt, fmeta_cnt_nxt;
  count_t offset_nxt;
  logic   step;

  assign step = s1_valid_r && adv;

  assign free_cnt_nxt  = (cls.kind == CNT_FREE && free_cnt_r != CNT_MAX)
                         ? free_cnt_r + 32'd1 : free_cnt_r;
  assign inode_cnt_nxt = (cls.kind == CNT_INODE && inode_cnt_r != CNT_MAX)
                         ? inode_cnt_r + 32'd1 : inode_cnt_r;
  assign meta_cnt_nxt  = (cls.kind == CNT_META && meta_cnt_r != CNT_MAX)
                         ? meta_cnt_r + 32'd1 : meta_cnt_r;
  assign fmeta_cnt_nxt = (cls.kind == CNT_FREE_META && fmeta_cnt_r != CNT_MAX)
                         ? fmeta_cnt_r + 32'd1 : fmeta_cnt_r;
  assign offset_nxt    = offset_r + 32'd1;   // wraps

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= '0;
      free_cnt_r  <= '0;
      inode_cnt_r <= '0;
      meta_cnt_r  <= '0;
      fmeta_cnt_r <= '0;
    end else if (step) begin
      if (s1_last_r) begin
        // group closed: start the next one from zero
        offset_r    <= '0;
        free_cnt_r  <= '0;
        inode_cnt_r <= '0;
        meta_cnt_r  <= '0;
        fmeta_cnt_r <= '0;
      end else begin
        offset_r    <= offset_nxt;
        free_cnt_r  <= free_cnt_nxt;
        inode_cnt_r <= inode_cnt_nxt;
        meta_cnt_r  <= meta_cnt_nxt;
        fmeta_cnt_r <= fmeta_cnt_nxt;
      end
    end
  end

  // --------------------------------------------------- header comparison
  // Free-inode blocks are never counted, so that header field is checked
  // against zero.
  cnt_mask_t mask;
  action_t   action;

  always_comb begin
    mask = '0;
    if (hdr_free_r       != free_cnt_nxt)  mask = mask | MASK_FREE;
    if (hdr_used_inode_r != inode_cnt_nxt) mask = mask | MASK_USED_INODE;
    if (hdr_free_inode_r != '0)            mask = mask | MASK_FREE_INODE;
    if (hdr_used_meta_r  != meta_cnt_nxt)  mask = mask | MASK_USED_META;
    if (hdr_free_meta_r  != fmeta_cnt_nxt) mask = mask | MASK_FREE_META;
    if (mask == '0)                              action = HA_NONE;
    else if ((mask & ~CONVERT_ONLY_BITS) == '0)  action = HA_CONVERT;
    else                                         action = HA_FULL;
  end

  // ------------------------------------------------------- result register
  blkno_t    blkno_r;
  logic      mism_r, sum_valid_r;
  state_t    exp_r;
  fix_t      fix_r;
  cnt_mask_t mask_r;
  action_t   action_r;
  count_t    free_tot_r, inode_tot_r, meta_tot_r, fmeta_tot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      blkno_r     <= first_data_block_r + {32'd0, offset_r};   // wraps mod 2^64
      mism_r      <= cls.mismatch;
      exp_r       <= cls.expected;
      fix_r       <= cls.fix;
      sum_valid_r <= s1_last_r;
      // summary fields read zero except on the group's last block
      mask_r      <= s1_last_r ? mask          : '0;
      action_r    <= s1_last_r ? action        : HA_NONE;
      free_tot_r  <= s1_last_r ? free_cnt_nxt  : '0;
      inode_tot_r <= s1_last_r ? inode_cnt_nxt : '0;
      meta_tot_r  <= s1_last_r ? meta_cnt_nxt  : '0;
      fmeta_tot_r <= s1_last_r ? fmeta_cnt_nxt : '0;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.block_number        = blkno_r;
  assign out_ch.mismatch            = mism_r;
  assign out_ch.expected_state      = exp_r;
  assign out_ch.fix_kind            = fix_r;
  assign out_ch.summary_valid       = sum_valid_r;
  assign out_ch.count_mismatch_mask = mask_r;
  assign out_ch.header_action       = action_r;
  assign out_ch.free_total          = free_tot_r;
  assign out_ch.used_inode_total    = inode_tot_r;
  assign out_ch.used_meta_total     = meta_tot_r;
  assign out_ch.free_meta_total     = fmeta_tot_r;

endmodule

@@ rtl/bbr_checker.sv @@
// bbr_checker: port-level assertions for the block bitmap reconciler, and
// the bind that attaches them. Depends on bbr_pkg.
module bbr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input bbr_pkg::blkno_t     out_block_number,
  input logic                out_mismatch,
  input bbr_pkg::fix_t       out_fix_kind,
  input logic                out_summary_valid,
  input bbr_pkg::cnt_mask_t  out_count_mismatch_mask,
  input bbr_pkg::action_t    out_header_action,
  input bbr_pkg::count_t     out_free_total,
  input bbr_pkg::count_t     out_used_inode_total,
  input bbr_pkg::count_t     out_used_meta_total,
  input bbr_pkg::count_t     out_free_meta_total
);
  import bbr_pkg::*;

  // a waiting result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_block_number)
      && $stable(out_summary_valid))
    else $error("stalled result changed");

  // fix kind is set exactly when a mismatch is reported
  a_fix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mismatch == (out_fix_kind != FIX_NONE)))
    else $error("fix kind disagrees with mismatch");

  // summary fields are zero off the last block
  a_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_summary_valid |->
      out_count_mismatch_mask == '0 && out_header_action == HA_NONE &&
      out_free_total == '0 && out_used_inode_total == '0 &&
      out_used_meta_total == '0 && out_free_meta_total == '0)
    else $error("summary fields set off the last block");

  // header action follows the mask
  a_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_summary_valid |->
      ((out_count_mismatch_mask == '0) == (out_header_action == HA_NONE)) &&
      (((out_count_mismatch_mask & ~CONVERT_ONLY_BITS) != '0) ==
        (out_header_action == HA_FULL)))
    else $error("header action inconsistent with mask");

endmodule

bind block_bitmap_reconciler_unit bbr_checker u_bbr_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .out_valid               (out_ch.valid),
  .out_ready               (out_ch.ready),
  .out_block_number        (out_ch.block_number),
  .out_mismatch            (out_ch.mismatch),
  .out_fix_kind            (out_ch.fix_kind),
  .out_summary_valid       (out_ch.summary_valid),
  .out_count_mismatch_mask (out_ch.count_mismatch_mask),
  .out_header_action       (out_ch.header_action),
  .out_free_total          (out_ch.free_total),
  .out_used_inode_total    (out_ch.used_inode_total),
  .out_used_meta_total     (out_ch.used_meta_total),
  .out_free_meta_total     (out_ch.free_meta_total)
);

@@ test/tb_top.sv @@
// tb_top: self-checking bench for block_bitmap_reconciler_unit, driven through
// the bbr_in_if / bbr_out_if channels and the plain register write port.
// Depends on bbr_pkg, bbr_if and the reconciler RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bbr_pkg::*;

  // index 7 is not a register; writes to it must be dropped by the block
  localparam cfg_idx_t CFG_SPARE   = 3'd7;
  localparam int       CYCLE_LIMIT = 400000;
  localparam int       N_ITEMS     = 1050;
  localparam int       MAX_PRINTS  = 40;

  // one bitmap entry as offered on the input channel
  typedef struct packed {
    state_t disk;
    mark_t  mark;
    logic   last;
  } blk_item_t;

  // what the block must return for one bitmap entry
  typedef struct packed {
    blkno_t    blkno;
    logic      mism;
    state_t    exp_st;
    fix_t      fix;
    logic      summ;
    cnt_mask_t mask;
    action_t   act;
    count_t    free_t;
    count_t    inode_t;
    count_t    meta_t;
    count_t    fmeta_t;
  } verdict_t;

  // shadow of the configuration registers
  typedef struct packed {
    blkno_t first;
    count_t hdr_free;
    count_t hdr_used_inode;
    count_t hdr_free_inode;
    count_t hdr_used_meta;
    count_t hdr_free_meta;
    logic   ro;
  } cfg_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  cfg_idx_t    cfg_index;
  logic [63:0] cfg_wdata;

  bbr_in_if  in_ch();
  bbr_out_if out_ch();

  block_bitmap_reconciler_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Shadow state of the reconciler: configuration plus group counters.
  // All of it is zero after reset, like the block.
  // ---------------------------------------------------------------------------
  cfg_t   cfg = '0;
  count_t grp_offset = '0;
  count_t cnt_free = '0;
  count_t cnt_inode = '0;
  count_t cnt_meta = '0;
  count_t cnt_fmeta = '0;

  blk_item_t block_q[$];    // items waiting for the driver
  verdict_t  verdict_q[$];  // expected results, oldest first

  int   n_queued = 0;
  int   n_results = 0;
  int   err_cnt = 0;
  int   cycles = 0;
  bit   tx_idle_en = 1'b1;
  bit   rx_idle_en = 1'b1;

  // driver and receiver bookkeeping
  blk_item_t tx_item;
  bit        tx_loaded = 1'b0;
  int        tx_wait = 0;
  int        rx_wait = 0;
  int        rx_taken = 0;
  bit        rx_long_done = 1'b0;
  verdict_t  got_v;

  // allocation state implied by a checker mark
  function automatic state_t state_of(mark_t mark);
    if (mark == MARK_FREE || mark == MARK_BAD_META) return ST_FREE;
    if (mark == MARK_FREE_META) return ST_FREE_META;
    if (mark == MARK_USED) return ST_USED;
    return ST_USED_META;   // inode kinds and every other metadata kind
  endfunction

  function automatic count_t sat_bump(count_t c);
    return (c == CNT_MAX) ? c : c + 32'd1;
  endfunction

  // Classifies one bitmap entry against the shadow config, updates the group
  // counters and, on the last block, produces the header summary.
  function automatic verdict_t reconcile_block(state_t disk, mark_t mark, logic last);
    verdict_t v;
    v = '0;
    v.exp_st = state_of(mark);
    if (mark == MARK_FREE || mark == MARK_BAD_META) cnt_free = sat_bump(cnt_free);
    else if (mark == MARK_FREE_META) cnt_fmeta = sat_bump(cnt_fmeta);
    else if (mark == MARK_USED) ;
    else if (mark <= MARK_INODE_HI) cnt_inode = sat_bump(cnt_inode);
    else cnt_meta = sat_bump(cnt_meta);

    v.mism = (disk != v.exp_st);
    if (!v.mism) v.fix = FIX_NONE;
    else if (disk == ST_FREE_META && v.exp_st == ST_FREE) v.fix = cfg.ro ? FIX_RO : FIX_AUTO;
    else v.fix = FIX_CONFIRM;

    v.blkno = cfg.first + {32'd0, grp_offset};   // wraps modulo 2^64
    grp_offset = grp_offset + 32'd1;

    if (last) begin
      if (cfg.hdr_free != cnt_free) v.mask |= MASK_FREE;
      if (cfg.hdr_used_inode != cnt_inode) v.mask |= MASK_USED_INODE;
      // free-inode blocks are never counted, so the header is held against zero
      if (cfg.hdr_free_inode != '0) v.mask |= MASK_FREE_INODE;
      if (cfg.hdr_used_meta != cnt_meta) v.mask |= MASK_USED_META;
      if (cfg.hdr_free_meta != cnt_fmeta) v.mask |= MASK_FREE_META;
      if (v.mask == '0) v.act = HA_NONE;
      else if ((v.mask & ~CONVERT_ONLY_BITS) == '0) v.act = HA_CONVERT;
      else v.act = HA_FULL;
      v.summ    = 1'b1;
      v.free_t  = cnt_free;
      v.inode_t = cnt_inode;
      v.meta_t  = cnt_meta;
      v.fmeta_t = cnt_fmeta;
      grp_offset = '0;
      cnt_free   = '0;
      cnt_inode  = '0;
      cnt_meta   = '0;
      cnt_fmeta  = '0;
    end
    return v;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS)
      $display("[%0t] result %0d: %s got 0x%0h want 0x%0h", $realtime, n_results, what,
               got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: pulls items from block_q, may wait a random gap before each one and
  // holds valid until the block takes it. When the next item has no gap, valid
  // simply stays high across the handshake.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      tx_loaded = 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (!tx_loaded && block_q.size() != 0) begin
        tx_item   = block_q.pop_front();
        tx_loaded = 1'b1;
        tx_wait   = (tx_idle_en && $urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
      end
      if (tx_loaded && tx_wait == 0) begin
        in_ch.valid      <= 1'b1;
        in_ch.disk_state <= tx_item.disk;
        in_ch.block_mark <= tx_item.mark;
        in_ch.last_block <= tx_item.last;
        tx_loaded = 1'b0;
      end else begin
        in_ch.valid <= 1'b0;
        if (tx_loaded) tx_wait--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: after each taken result it may stall for a random number of
  // cycles. Once, with plenty of input still queued, it holds off for a long
  // stretch so both internal registers fill and the input side backs up.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        rx_taken++;
        rx_wait = (rx_idle_en && $urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
        if (!rx_long_done && rx_taken >= 300 && block_q.size() > 8) begin
          rx_wait      = 160;
          rx_long_done = 1'b1;
        end
      end
      if (rx_wait != 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted item, then checks every taken result
  // against the oldest expectation. Prediction comes first so ordering holds
  // even if a result showed up in the same cycle as its item.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        verdict_q.push_back(reconcile_block(in_ch.disk_state, in_ch.block_mark,
                                            in_ch.last_block));
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          report("result with nothing expected, block_number", out_ch.block_number, '0);
        end else begin
          got_v = verdict_q.pop_front();
          if (out_ch.block_number !== got_v.blkno)
            report("block_number", out_ch.block_number, got_v.blkno);
          if (out_ch.mismatch !== got_v.mism)
            report("mismatch", 64'(out_ch.mismatch), 64'(got_v.mism));
          if (out_ch.expected_state !== got_v.exp_st)
            report("expected_state", 64'(out_ch.expected_state), 64'(got_v.exp_st));
          if (out_ch.fix_kind !== got_v.fix)
            report("fix_kind", 64'(out_ch.fix_kind), 64'(got_v.fix));
          if (out_ch.summary_valid !== got_v.summ)
            report("summary_valid", 64'(out_ch.summary_valid), 64'(got_v.summ));
          if (out_ch.count_mismatch_mask !== got_v.mask)
            report("count_mismatch_mask", 64'(out_ch.count_mismatch_mask),
                   64'(got_v.mask));
          if (out_ch.header_action !== got_v.act)
            report("header_action", 64'(out_ch.header_action), 64'(got_v.act));
          if (out_ch.free_total !== got_v.free_t)
            report("free_total", 64'(out_ch.free_total), 64'(got_v.free_t));
          if (out_ch.used_inode_total !== got_v.inode_t)
            report("used_inode_total", 64'(out_ch.used_inode_total), 64'(got_v.inode_t));
          if (out_ch.used_meta_total !== got_v.meta_t)
            report("used_meta_total", 64'(out_ch.used_meta_total), 64'(got_v.meta_t));
          if (out_ch.free_meta_total !== got_v.fmeta_t)
            report("free_meta_total", 64'(out_ch.free_meta_total), 64'(got_v.fmeta_t));
        end
        n_results++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_block(state_t disk, mark_t mark, logic last);
    blk_item_t it;
    it.disk = disk;
    it.mark = mark;
    it.last = last;
    block_q.push_back(it);
    n_queued++;
  endtask

  // mostly the consistent state, often the free-meta-on-disk case, else noise
  function automatic state_t pick_disk(mark_t mark);
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return state_of(mark);
    if (r < 7 && state_of(mark) == ST_FREE) return ST_FREE_META;
    return state_t'($urandom_range(0, 3));
  endfunction

  // Group with exactly the given counts (used blocks are not counted),
  // shuffled, closed by a last block.
  task automatic queue_group(int n_free, int n_inode, int n_meta, int n_fmeta, int n_used);
    mark_t marks[$];
    mark_t tmp;
    int    j;
    repeat (n_free) marks.push_back($urandom_range(0, 1) ? MARK_FREE : MARK_BAD_META);
    repeat (n_inode) marks.push_back(mark_t'($urandom_range(MARK_INODE_LO, MARK_INODE_HI)));
    repeat (n_meta) marks.push_back(mark_t'($urandom_range(MARK_INDIR, MARK_XATTR)));
    repeat (n_fmeta) marks.push_back(MARK_FREE_META);
    repeat (n_used) marks.push_back(MARK_USED);
    if (marks.size() == 0) marks.push_back(MARK_USED);
    for (int k = marks.size() - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = marks[k];
      marks[k] = marks[j];
      marks[j] = tmp;
    end
    foreach (marks[k]) queue_block(pick_disk(marks[k]), marks[k], k == marks.size() - 1);
  endtask

  // Fully random entries; now and then the group is left open so it carries
  // over into the next one.
  task automatic queue_noise(int len);
    for (int k = 0; k < len; k++)
      queue_block(state_t'($urandom_range(0, 3)), mark_t'($urandom_range(0, 15)),
                  k == len - 1 && $urandom_range(0, 4) != 0);
  endtask

  task automatic put_reg(cfg_idx_t idx, logic [63:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
  endtask

  // Writes every register (junk in the unused upper bits) plus the spare index.
  task automatic load_cfg(cfg_t c);
    put_reg(CFG_FIRST_DATA_BLOCK, c.first);
    put_reg(CFG_HDR_FREE, {$urandom(), c.hdr_free});
    put_reg(CFG_HDR_USED_INODE, {$urandom(), c.hdr_used_inode});
    put_reg(CFG_HDR_FREE_INODE, {$urandom(), c.hdr_free_inode});
    put_reg(CFG_HDR_USED_META, {$urandom(), c.hdr_used_meta});
    put_reg(CFG_HDR_FREE_META, {$urandom(), c.hdr_free_meta});
    put_reg(CFG_READ_ONLY, {$urandom(), 31'($urandom()), c.ro});
    put_reg(CFG_SPARE, {$urandom(), $urandom()});
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg = c;
  endtask

  // Waits until every queued item has gone in and every result has come out.
  // Sampled on the falling edge so the check never races the clocked blocks.
  task automatic drain();
    while (block_q.size() != 0 || tx_loaded || in_ch.valid || verdict_q.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    cfg_t nc;
    int   f;
    int   ino;
    int   mt;
    int   fm;
    int   phase;

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_FIRST_DATA_BLOCK;
    cfg_wdata        = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed group 1: every mark once with disk = mark[1:0], then the
    // free-meta-on-disk case for both free marks. Header matches exactly and
    // the block number wraps past 2^64 inside the group.
    nc = '0;
    nc.first          = 64'hFFFF_FFFF_FFFF_FFF8;
    nc.hdr_free       = 4;
    nc.hdr_used_inode = 7;
    nc.hdr_used_meta  = 5;
    nc.hdr_free_meta  = 1;
    load_cfg(nc);
    for (int k = 0; k < 16; k++) queue_block(state_t'(k % 4), mark_t'(k), 1'b0);
    queue_block(ST_FREE_META, MARK_FREE, 1'b0);
    queue_block(ST_FREE_META, MARK_BAD_META, 1'b1);
    drain();

    // Directed group 2: read-only suppresses the conversion; all-ones header
    // counts force a full update.
    nc = '0;
    nc.hdr_free       = CNT_MAX;
    nc.hdr_free_inode = CNT_MAX;
    nc.ro             = 1'b1;
    load_cfg(nc);
    queue_block(ST_FREE_META, MARK_FREE, 1'b0);
    queue_block(ST_USED, MARK_USED, 1'b1);
    drain();

    // Directed group 3: only the free count is off -> convert-only; then a
    // one-block group that also misses the meta count -> full update.
    nc = '0;
    nc.first         = '1;
    nc.hdr_free      = 5;
    nc.hdr_free_meta = 1;
    load_cfg(nc);
    queue_block(ST_FREE, MARK_FREE_META, 1'b0);
    queue_block(ST_FREE_META, MARK_FREE, 1'b1);
    queue_block(ST_USED_META, MARK_XATTR, 1'b1);

    // Random phases: each picks target counts and a header that matches them
    // or misses in a chosen way, then sends mostly well-formed groups of those
    // counts plus some random ones.
    phase = 0;
    while (n_queued < N_ITEMS) begin
      drain();
      f   = $urandom_range(0, 5);
      ino = $urandom_range(0, 5);
      mt  = $urandom_range(0, 5);
      fm  = $urandom_range(0, 3);
      if ($urandom_range(0, 7) == 0) f = $urandom_range(10, 20);

      case ($urandom_range(0, 3))
        0: nc.first = '0;
        1: nc.first = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 30));
        default: nc.first = {$urandom(), $urandom()};
      endcase
      nc.hdr_free       = f;
      nc.hdr_used_inode = ino;
      nc.hdr_free_inode = '0;
      nc.hdr_used_meta  = mt;
      nc.hdr_free_meta  = fm;
      nc.ro             = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 6))
        1: nc.hdr_free = f - 1;            // zero target gives all ones
        2: nc.hdr_free_meta = fm + 1;
        3: begin
          nc.hdr_free      = $urandom();
          nc.hdr_free_meta = $urandom();
        end
        4: nc.hdr_used_inode = $urandom();
        5: nc.hdr_used_meta = mt + $urandom_range(1, 3);
        6: nc.hdr_free_inode = $urandom_range(0, 1) ? CNT_MAX : count_t'($urandom());
        default: ;
      endcase
      load_cfg(nc);

      // some phases run with no idling at all on one or both sides
      tx_idle_en = (phase % 5 != 3);
      rx_idle_en = (phase % 4 != 1);

      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 9) < 7) queue_group(f, ino, mt, fm, $urandom_range(0, 3));
        else queue_noise($urandom_range(1, 10));
      end
      phase++;
    end

    drain();
    repeat (5) @(posedge clk);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bbr_pkg.sv
rtl/bbr_if.sv
rtl/bbr_classify.sv
rtl/block_bitmap_reconciler_unit.sv
rtl/bbr_checker.sv
test/tb_top.sv
